>>> rtl/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg: shared types and constants of the keypad debounce event queue
// Command codes, sequencer states, per-key state and push request structs.
// ----------------------------------------------------------------------------
package mkd_pkg;

    localparam int NUM_KEYS = 12;
    localparam int KEY_W    = 4;
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

    localparam int FILTER_RESET_VAL = 5;
    localparam logic [6:0] FILTER_RESET = 7'(FILTER_RESET_VAL);
    localparam logic [7:0] COUNT_RESET  = 8'(FILTER_RESET_VAL / 2);

    localparam logic [2:0] CMD_SCAN      = 3'd0;
    localparam logic [2:0] CMD_POP_PRI   = 3'd1;
    localparam logic [2:0] CMD_POP_SEC   = 3'd2;
    localparam logic [2:0] CMD_CLEAR_PRI = 3'd3;
    localparam logic [2:0] CMD_PUSH      = 3'd4;
    localparam logic [2:0] CMD_SET_KEY   = 3'd5;

    localparam logic [1:0] LAST_COL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_PUSH2,
        ST_POP_DATA,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0]  count;
        logic        pressed;
        logic [15:0] long_cnt;
        logic [7:0]  rep_cnt;
    } key_state_t;

    typedef struct packed {
        logic       first_en;
        logic [7:0] first_code;
        logic       second_en;
        logic [7:0] second_code;
    } key_push_t;

endpackage

>>> rtl/mkd_if.sv
// ----------------------------------------------------------------------------
// mkd_if: valid/ready channels of the keypad debounce event queue
// Command channel toward the block and result channel out of it.
// ----------------------------------------------------------------------------
interface mkd_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [2:0]  row1_columns;
    logic [2:0]  row2_columns;
    logic [2:0]  row3_columns;
    logic [2:0]  row4_columns;
    logic [7:0]  push_code;
    logic [3:0]  key_index;
    logic [15:0] new_long_time;
    logic [7:0]  new_repeat_period;

    modport source (
        output valid, command, row1_columns, row2_columns, row3_columns,
               row4_columns, push_code, key_index, new_long_time, new_repeat_period,
        input  ready
    );
    modport sink (
        input  valid, command, row1_columns, row2_columns, row3_columns,
               row4_columns, push_code, key_index, new_long_time, new_repeat_period,
        output ready
    );
endinterface

interface mkd_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  event_code;
    logic        event_valid;
    logic [11:0] pressed_map;

    modport source (
        output valid, event_code, event_valid, pressed_map,
        input  ready
    );
    modport sink (
        input  valid, event_code, event_valid, pressed_map,
        output ready
    );
endinterface

>>> rtl/matrix_key_debounce_event_fifo_unit.sv
// ----------------------------------------------------------------------------
// matrix_key_debounce_event_fifo_unit: 4x3 keypad debounce with event queue
// Debounces twelve keys, detects press, release, long press and auto-repeat,
// and queues event codes in a ring read through two independent pointers.
//
// req carries one command per transaction; rsp returns one result per
// command: the popped code, its valid flag and the debounced pressed map.
// cfg_we/cfg_wdata write the debounce filter time (reset value 5).
// The block takes one command at a time. A scan tick walks the keys one per
// cycle through a single key update unit, pausing in a second push state
// for each key that pushes two codes, since the queue RAM has one write
// port. A pop reads the registered RAM output in a data state, which an
// empty queue skips.
// A result waits in the output register while rsp stalls; the next command
// is still accepted and runs, then holds until that register frees up.
// Reset clears keys and pointers and restores the per-key settings at once;
// queue entries are left as they are and are only read after being written.
// ----------------------------------------------------------------------------
module matrix_key_debounce_event_fifo_unit #(
    parameter int          QUEUE_DEPTH       = 16,
    parameter logic [15:0] DEFAULT_LONG_TIME = 16'd100
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    mkd_req_if.sink     req,
    mkd_rsp_if.source   rsp
);
    import mkd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
        ptr_step = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    state_t      state_reg, state_next;
    logic [6:0]  filter_reg;
    logic [2:0]  cmd_reg;
    logic [2:0]  rows_reg [4];
    logic [7:0]  push_code_reg;
    logic [3:0]  key_index_reg;
    logic [15:0] long_in_reg;
    logic [7:0]  period_in_reg;

    logic [7:0]  count_reg     [NUM_KEYS];
    logic [NUM_KEYS-1:0] pressed_reg;
    logic [15:0] long_cnt_reg  [NUM_KEYS];
    logic [7:0]  rep_cnt_reg   [NUM_KEYS];
    logic [15:0] long_time_reg [NUM_KEYS];
    logic [7:0]  period_reg    [NUM_KEYS];

    logic [KEY_W-1:0] key_cnt_reg, key_cnt_next;
    logic [1:0]  row_reg, row_next;
    logic [1:0]  col_reg, col_next;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp1_reg, rp1_next;
    logic [PTR_W-1:0] rp2_reg, rp2_next;
    logic [7:0]  pend_code_reg, pend_code_next;
    logic [7:0]  code_reg, code_next;
    logic        flag_reg, flag_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_code_reg;
    logic        out_flag_reg;
    logic [11:0] out_map_reg;

    logic        accept;
    logic        down;
    logic        pop_empty;
    logic        set_hit;
    logic        load;
    logic        ram_we;
    logic [7:0]  ram_wdata;
    logic [PTR_W-1:0] ram_raddr;
    logic [7:0]  ram_rdata;
    key_state_t  key_cur;
    key_state_t  key_next;
    key_push_t   key_push;

    assign accept    = req.valid && req.ready;
    assign down      = rows_reg[row_reg] == (3'b001 << col_reg);
    assign ram_raddr = (cmd_reg == CMD_POP_SEC) ? rp2_reg : rp1_reg;
    assign pop_empty = ram_raddr == wp_reg;
    assign set_hit   = (state_reg == ST_EXEC) && (cmd_reg == CMD_SET_KEY)
                       && (key_index_reg <= LAST_KEY);
    assign load      = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    assign key_cur.count    = count_reg[key_cnt_reg];
    assign key_cur.pressed  = pressed_reg[key_cnt_reg];
    assign key_cur.long_cnt = long_cnt_reg[key_cnt_reg];
    assign key_cur.rep_cnt  = rep_cnt_reg[key_cnt_reg];

    mkd_key_unit u_key (
        .filter    (filter_reg),
        .down      (down),
        .key_num   (key_cnt_reg),
        .long_time (long_time_reg[key_cnt_reg]),
        .period    (period_reg[key_cnt_reg]),
        .cur       (key_cur),
        .nxt       (key_next),
        .push      (key_push)
    );

    mkd_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (cmd_reg) inside
                    CMD_SCAN:                 state_next = ST_SCAN;
                    CMD_POP_PRI, CMD_POP_SEC: state_next = pop_empty ? ST_FINISH : ST_POP_DATA;
                    default:                  state_next = ST_FINISH;
                endcase
            end
            ST_SCAN:
            begin
                if (key_push.second_en)
                begin
                    state_next = ST_PUSH2;
                end
                else if (key_cnt_reg == LAST_KEY)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PUSH2:
            begin
                state_next = (key_cnt_reg == '0) ? ST_FINISH : ST_SCAN;
            end
            ST_POP_DATA:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = push_code_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_EXEC:
            begin
                ram_we = cmd_reg == CMD_PUSH;
            end
            ST_SCAN:
            begin
                ram_we    = key_push.first_en;
                ram_wdata = key_push.first_code;
            end
            ST_PUSH2:
            begin
                ram_we    = 1'b1;
                ram_wdata = pend_code_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        key_cnt_next   = key_cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rp1_next       = rp1_reg;
        rp2_next       = rp2_reg;
        pend_code_next = pend_code_reg;
        code_next      = code_reg;
        flag_next      = flag_reg;
        wp_next        = ram_we ? ptr_step(wp_reg) : wp_reg;

        if (state_reg == ST_EXEC)
        begin
            key_cnt_next = '0;
            row_next     = 2'd0;
            col_next     = 2'd0;
            code_next    = 8'd0;
            flag_next    = 1'b0;
            if (cmd_reg == CMD_CLEAR_PRI)
            begin
                rp1_next = wp_reg;
            end
        end

        if (state_reg == ST_SCAN)
        begin
            pend_code_next = key_push.second_code;
            if (key_cnt_reg == LAST_KEY)
            begin
                key_cnt_next = '0;
                row_next     = 2'd0;
                col_next     = 2'd0;
            end
            else
            begin
                key_cnt_next = key_cnt_reg + KEY_W'(1);
                if (col_reg == LAST_COL)
                begin
                    col_next = 2'd0;
                    row_next = row_reg + 2'd1;
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
            end
        end

        if (state_reg == ST_POP_DATA)
        begin
            code_next = ram_rdata;
            flag_next = 1'b1;
            if (cmd_reg == CMD_POP_SEC)
            begin
                rp2_next = ptr_step(rp2_reg);
            end
            else
            begin
                rp1_next = ptr_step(rp1_reg);
            end
        end

        out_valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filter_reg    <= FILTER_RESET;
            key_cnt_reg   <= '0;
            row_reg       <= 2'd0;
            col_reg       <= 2'd0;
            wp_reg        <= '0;
            rp1_reg       <= '0;
            rp2_reg       <= '0;
            out_valid_reg <= 1'b0;
            pressed_reg   <= '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                count_reg[k]     <= COUNT_RESET;
                long_cnt_reg[k]  <= 16'd0;
                rep_cnt_reg[k]   <= 8'd0;
                long_time_reg[k] <= DEFAULT_LONG_TIME;
                period_reg[k]    <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            key_cnt_reg   <= key_cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            wp_reg        <= wp_next;
            rp1_reg       <= rp1_next;
            rp2_reg       <= rp2_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                filter_reg <= cfg_wdata;
            end
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if ((state_reg == ST_SCAN) && (key_cnt_reg == KEY_W'(k)))
                begin
                    count_reg[k]    <= key_next.count;
                    pressed_reg[k]  <= key_next.pressed;
                    long_cnt_reg[k] <= key_next.long_cnt;
                    rep_cnt_reg[k]  <= key_next.rep_cnt;
                end
                if (set_hit && (key_index_reg == KEY_W'(k)))
                begin
                    long_time_reg[k] <= long_in_reg;
                    period_reg[k]    <= period_in_reg;
                    rep_cnt_reg[k]   <= 8'd0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_code_reg <= pend_code_next;
        code_reg      <= code_next;
        flag_reg      <= flag_next;
        if (accept)
        begin
            cmd_reg       <= req.command;
            rows_reg[0]   <= req.row1_columns;
            rows_reg[1]   <= req.row2_columns;
            rows_reg[2]   <= req.row3_columns;
            rows_reg[3]   <= req.row4_columns;
            push_code_reg <= req.push_code;
            key_index_reg <= req.key_index;
            long_in_reg   <= req.new_long_time;
            period_in_reg <= req.new_repeat_period;
        end
        if (load)
        begin
            out_code_reg <= code_reg;
            out_flag_reg <= flag_reg;
            out_map_reg  <= pressed_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.event_code  = out_code_reg;
    assign rsp.event_valid = out_flag_reg;
    assign rsp.pressed_map = out_map_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("command accepted while previous one in flight");

    a_push2_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH2) |-> ($past(state_reg) == ST_SCAN))
        else $error("second push outside key scan");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && out_valid_reg && !rsp.ready) |=>
        ((state_reg == ST_FINISH) && out_valid_reg))
        else $error("result overwrote a pending transaction");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        (key_cnt_reg <= LAST_KEY) && (col_reg <= LAST_COL))
        else $error("key sequencer out of range");

endmodule

>>> rtl/mkd_ram.sv
// ----------------------------------------------------------------------------
// mkd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mkd_key_unit.sv
// ----------------------------------------------------------------------------
// mkd_key_unit: shared one-key debounce and timing update
// Given one key's state and reading, forms its next state and queue pushes.
// ----------------------------------------------------------------------------
module mkd_key_unit (
    input  logic [6:0]          filter,
    input  logic                down,
    input  logic [3:0]          key_num,
    input  logic [15:0]         long_time,
    input  logic [7:0]          period,
    input  mkd_pkg::key_state_t cur,
    output mkd_pkg::key_state_t nxt,
    output mkd_pkg::key_push_t  push
);
    import mkd_pkg::*;

    logic [7:0]  f8;
    logic [7:0]  twof;
    logic [7:0]  base;
    logic [15:0] long_plus;
    logic [7:0]  rep_plus;
    logic        press_push;
    logic        other_push;
    logic [7:0]  other_code;

    assign f8        = {1'b0, filter};
    assign twof      = {filter, 1'b0};
    assign base      = {3'b000, key_num, 1'b0} + {4'b0000, key_num};
    assign long_plus = cur.long_cnt + 16'd1;
    assign rep_plus  = cur.rep_cnt + 8'd1;

    always_comb
    begin
        nxt        = cur;
        press_push = 1'b0;
        other_push = 1'b0;
        other_code = base + 8'd1;
        if (down)
        begin
            if (cur.count < f8)
            begin
                nxt.count = f8;
            end
            else if (cur.count < twof)
            begin
                nxt.count = cur.count + 8'd1;
            end
            else
            begin
                if (!cur.pressed)
                begin
                    nxt.pressed = 1'b1;
                    press_push  = 1'b1;
                end
                if (long_time != 16'd0)
                begin
                    if (cur.long_cnt < long_time)
                    begin
                        nxt.long_cnt = long_plus;
                        if (long_plus == long_time)
                        begin
                            other_push = 1'b1;
                            other_code = base + 8'd3;
                        end
                    end
                    else if (period != 8'd0)
                    begin
                        nxt.rep_cnt = rep_plus;
                        if (rep_plus >= period)
                        begin
                            nxt.rep_cnt = 8'd0;
                            other_push  = 1'b1;
                        end
                    end
                end
            end
        end
        else
        begin
            if (cur.count > f8)
            begin
                nxt.count = f8;
            end
            else if (cur.count != 8'd0)
            begin
                nxt.count = cur.count - 8'd1;
            end
            else if (cur.pressed)
            begin
                nxt.pressed = 1'b0;
                other_push  = 1'b1;
                other_code  = base + 8'd2;
            end
            nxt.long_cnt = 16'd0;
            nxt.rep_cnt  = 8'd0;
        end
    end

    always_comb
    begin
        push.first_en    = press_push || other_push;
        push.first_code  = press_push ? (base + 8'd1) : other_code;
        push.second_en   = press_push && other_push;
        push.second_code = other_code;
    end

endmodule
